@@ hw/rtl/text_console_cell_writer_defines.svh @@
// ----------------------------------------------------------------------------
// text_console_cell_writer_defines
// Assertion macros shared by the console checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CELL_WRITER_DEFINES_SVH

// Checked only while out of reset.
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared codes, constants and request type of the text console cell writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int CELL_W = 16;

  localparam logic [2:0] ACT_PUT       = 3'd0;
  localparam logic [2:0] ACT_BACKSPACE = 3'd1;
  localparam logic [2:0] ACT_CLEAR     = 3'd2;
  localparam logic [2:0] ACT_SET       = 3'd3;
  localparam logic [2:0] ACT_READ      = 3'd4;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;

  localparam logic CFG_FG = 1'b0;
  localparam logic CFG_BG = 1'b1;

  localparam logic [3:0] RESET_FG = 4'd10;
  localparam logic [3:0] RESET_BG = 4'd0;

  // Tab stops every four columns.
  localparam int TAB_STEP = 4;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] char_code;
    logic [4:0] row_index;
    logic [6:0] col_index;
  } tcw_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/tcw_cell_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Character cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [tcw_pkg::CELL_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [tcw_pkg::CELL_W-1:0] rd_data
);

  logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
  logic [tcw_pkg::CELL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ hw/rtl/tcw_cursor.sv @@
// ----------------------------------------------------------------------------
// tcw_cursor
// Cursor registers, next-position logic and cell address generation.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cursor #(
  parameter int COLS = 80,
  parameter int ROWS = 25,
  parameter int AW   = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tcw_pkg::tcw_req_t req,
  input  logic              take,
  output logic [AW-1:0]     cell_addr,
  output logic              scroll_req,
  output logic [10:0]       cursor_pos
);

  localparam int RW  = $clog2(ROWS);
  localparam int CW  = $clog2(COLS);
  localparam int CXW = CW + 1;
  localparam int PW  = (AW > 11) ? AW : 11;
  localparam int TAB_STEP_C = tcw_pkg::TAB_STEP;

  logic [RW-1:0]  row_r, row_nxt, addr_row, set_row;
  logic [CW-1:0]  col_r, col_nxt, addr_col, set_col;
  logic [CXW-1:0] col_adv, tab_col;
  logic           scroll;
  logic [PW-1:0]  pos_full;

  always_comb begin
    set_row = (32'(req.row_index) > 32'(ROWS-1)) ? RW'(ROWS-1) : RW'(req.row_index);
    set_col = (32'(req.col_index) > 32'(COLS-1)) ? CW'(COLS-1) : CW'(req.col_index);
    tab_col = ({1'b0, col_r} + CXW'(TAB_STEP_C)) & ~CXW'(TAB_STEP_C - 1);

    // Newline forces a wrap by advancing to the column count itself.
    if (req.char_code == tcw_pkg::CHAR_NEWLINE) begin
      col_adv = CXW'(COLS);
    end else if (req.char_code == tcw_pkg::CHAR_TAB) begin
      col_adv = tab_col;
    end else begin
      col_adv = {1'b0, col_r} + CXW'(1);
    end

    row_nxt  = row_r;
    col_nxt  = col_r;
    scroll   = 1'b0;
    addr_row = row_r;
    addr_col = col_r;

    unique case (req.action)
      tcw_pkg::ACT_PUT: begin
        if (col_adv >= CXW'(COLS)) begin
          col_nxt = '0;
          if (row_r == RW'(ROWS-1)) begin
            scroll = 1'b1;
          end else begin
            row_nxt = row_r + RW'(1);
          end
        end else begin
          col_nxt = col_adv[CW-1:0];
        end
      end
      tcw_pkg::ACT_BACKSPACE: begin
        if (col_r != '0) begin
          col_nxt = col_r - CW'(1);
        end else if (row_r != '0) begin
          row_nxt = row_r - RW'(1);
          col_nxt = CW'(COLS-1);
        end
        // blank lands on the cell stepped back to
        addr_row = row_nxt;
        addr_col = col_nxt;
      end
      tcw_pkg::ACT_CLEAR: begin
        row_nxt = '0;
        col_nxt = '0;
      end
      tcw_pkg::ACT_SET: begin
        row_nxt = set_row;
        col_nxt = set_col;
      end
      tcw_pkg::ACT_READ: begin
        addr_row = set_row;
        addr_col = set_col;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (take) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  assign cell_addr  = AW'(addr_row) * AW'(COLS) + AW'(addr_col);
  assign pos_full   = PW'(row_r) * PW'(COLS) + PW'(col_r);
  assign cursor_pos = pos_full[10:0];
  assign scroll_req = scroll;

endmodule

`default_nettype wire

@@ hw/rtl/text_console_cell_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Put char, backspace, set cursor, read cell: the request passes the done state
// and its result is registered from there; in_stall stays high until the result
// is loaded, so no new request is taken until then. Clear and a scrolling put
// walk the store one cell a cycle through its single write port.
// After reset the store is blanked with in_stall high; configuration writes
// are taken during that pass.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cell_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_char_code,
  input  logic [3:0]  in_foreground,
  input  logic [3:0]  in_background,
  input  logic [4:0]  in_row_index,
  input  logic [6:0]  in_col_index,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_cursor_pos,
  output logic [7:0]  out_cell_char,
  output logic [7:0]  out_cell_attr,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CNTW  = $clog2(CELLS + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCROLL = 2'd1;
  localparam logic [1:0] ST_FILL   = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]      state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            fill_reset_r, fill_reset_nxt;
  logic [2:0]      act_r;
  logic [3:0]      fg_r, bg_r;

  logic            out_valid_r;
  logic [10:0]     out_pos_r;
  logic [7:0]      out_char_r, out_attr_r;

  tcw_pkg::tcw_req_t req;
  logic              in_accept, out_load, printable;
  logic [AW-1:0]     cur_addr;
  logic              scroll_req;
  logic [10:0]       cursor_pos;

  logic                       wr_en, rd_en;
  logic [AW-1:0]              wr_addr, rd_addr;
  logic [tcw_pkg::CELL_W-1:0] wr_data, rd_data, blank, reset_blank;

  assign req.action    = in_action;
  assign req.char_code = in_char_code;
  assign req.row_index = in_row_index;
  assign req.col_index = in_col_index;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign printable = (in_char_code != tcw_pkg::CHAR_NEWLINE) &&
                     (in_char_code != tcw_pkg::CHAR_TAB);

  assign blank       = {bg_r, fg_r, tcw_pkg::CHAR_SPACE};
  assign reset_blank = {tcw_pkg::RESET_BG, tcw_pkg::RESET_FG, tcw_pkg::CHAR_SPACE};

  tcw_cursor #(
    .COLS (COLS),
    .ROWS (ROWS),
    .AW   (AW)
  ) u_cursor (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .take       (in_accept),
    .cell_addr  (cur_addr),
    .scroll_req (scroll_req),
    .cursor_pos (cursor_pos)
  );

  tcw_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    fill_reset_nxt = fill_reset_r;
    wr_en          = 1'b0;
    wr_addr        = cur_addr;
    wr_data        = blank;
    rd_en          = 1'b0;
    rd_addr        = cur_addr;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_DONE;
          cnt_nxt   = '0;
          case (in_action)
            tcw_pkg::ACT_PUT: begin
              wr_en   = printable;
              wr_data = {in_background, in_foreground, in_char_code};
              if (scroll_req) begin
                state_nxt = ST_SCROLL;
              end
            end
            tcw_pkg::ACT_BACKSPACE: begin
              wr_en = 1'b1;
            end
            tcw_pkg::ACT_CLEAR: begin
              state_nxt      = ST_FILL;
              fill_reset_nxt = 1'b0;
            end
            tcw_pkg::ACT_READ: begin
              rd_en = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCROLL: begin
        // Read runs one row and one cell ahead of the write-back; the two never meet.
        if (cnt_r != CNTW'(CELLS-COLS)) begin
          rd_en   = 1'b1;
          rd_addr = AW'(cnt_r + CNTW'(COLS));
        end
        if (cnt_r != '0) begin
          wr_en   = 1'b1;
          wr_addr = AW'(cnt_r - CNTW'(1));
          wr_data = rd_data;
        end
        if (cnt_r == CNTW'(CELLS-COLS)) begin
          state_nxt = ST_FILL;
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end
      ST_FILL: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r[AW-1:0];
        wr_data = fill_reset_r ? reset_blank : blank;
        if (cnt_r == CNTW'(CELLS-1)) begin
          state_nxt      = fill_reset_r ? ST_IDLE : ST_DONE;
          fill_reset_nxt = 1'b0;
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_FILL;
      cnt_r        <= '0;
      fill_reset_r <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      fill_reset_r <= fill_reset_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      act_r <= in_action;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= tcw_pkg::RESET_FG;
      bg_r <= tcw_pkg::RESET_BG;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tcw_pkg::CFG_FG: fg_r <= cfg_data;
        tcw_pkg::CFG_BG: bg_r <= cfg_data;
      endcase
    end
  end

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos_r  <= cursor_pos;
      out_char_r <= (act_r == tcw_pkg::ACT_READ) ? rd_data[7:0] : 8'd0;
      out_attr_r <= (act_r == tcw_pkg::ACT_READ) ? rd_data[15:8] : 8'd0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_pos = out_pos_r;
  assign out_cell_char  = out_char_r;
  assign out_cell_attr  = out_attr_r;

endmodule

`default_nettype wire

@@ hw/rtl/tcw_checker.sv @@
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console cell writer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_cell_writer_defines.svh"

module tcw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [10:0] out_cursor_pos,
  input logic [7:0]  out_cell_char,
  input logic [7:0]  out_cell_attr
);

  // reset always starts the blanking pass
  `TCW_ASSERT_ALWAYS(a_reset_blanks, !rst_n |=> in_stall, "no blanking pass after reset")

  `TCW_ASSERT(a_busy_after_req, in_valid && !in_stall |=> in_stall, "request not held busy")

  `TCW_ASSERT(a_result_from_work, $rose(out_valid) |-> $past(in_stall), "result without work")

  `TCW_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_cursor_pos) && $stable(out_cell_char) && $stable(out_cell_attr), "stalled result changed")

endmodule

bind text_console_cell_writer tcw_checker u_tcw_checker (.*);

`default_nettype wire
